// ===== hdl/bilinear_bayer_demosaic_assert.svh =====
// assertion macros used by the demosaic top level
`ifndef BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH
`define BILINEAR_BAYER_DEMOSAIC_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bbd_pkg.sv =====
// types, constants and arithmetic helpers for the demosaic block
`default_nettype none

package bbd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COLOR_W      = 8;
    localparam int COL_OUT_W    = 12;
    localparam int ROW_W        = 14;
    localparam int ROW_CMP_W    = 15;
    localparam int WIDTH_CFG_W  = 13;
    localparam int HEIGHT_CFG_W = 15;
    localparam int CFG_DATA_W   = 15;
    localparam int CFG_IDX_W    = 1;
    localparam int SUM_W        = 18;
    localparam int MIN_DIM      = 4;
    localparam int HEIGHT_MAX   = 16384;
    localparam int COLOR_MAX    = 255;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int FIRST_OUT    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        SITE_GR,
        SITE_R,
        SITE_B,
        SITE_GB
    } t_site;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [2:0][2:0]  t_window;

    typedef struct packed {
        logic [COL_OUT_W-1:0] cc;
        logic [ROW_W-1:0]     cr;
        logic                 last;
        t_site                site;
    } t_tag;

    function automatic logic [SUM_W-1:0] pair_mean(input t_sample a, input t_sample b,
                                                   input int unsigned shift);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(1);
        return s >> (shift + 1);
    endfunction

    function automatic logic [SUM_W-1:0] quad_mean(input t_sample a, input t_sample b,
                                                   input t_sample c, input t_sample d,
                                                   input int unsigned shift);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(2);
        return s >> (shift + 2);
    endfunction

    function automatic logic [SUM_W-1:0] keep(input t_sample a, input int unsigned shift);
        return SUM_W'(a) >> shift;
    endfunction

    function automatic logic [COLOR_W-1:0] sat8(input logic [SUM_W-1:0] v);
        return (v > SUM_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX) : v[COLOR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bbd_line_store.sv =====
// one row of raw samples, one registered read and one write per cycle
`default_nettype none

module bbd_line_store #(
    parameter int DEPTH = 4096,
    parameter int ADDR_W = 12
) (
    input  wire                  i_clk,
    input  wire                  i_rd_en,
    input  wire [ADDR_W-1:0]     i_rd_addr,
    output logic [bbd_pkg::SAMPLE_W-1:0] o_rd_data,
    input  wire                  i_wr_en,
    input  wire [ADDR_W-1:0]     i_wr_addr,
    input  wire [bbd_pkg::SAMPLE_W-1:0]  i_wr_data
);

    bbd_pkg::t_sample r_mem [DEPTH];
    bbd_pkg::t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== hdl/bbd_color.sv =====
// color interpolation from the 3x3 window into the output register
`default_nettype none

module bbd_color #(
    parameter int DROP_SHIFT = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire bbd_pkg::t_window i_win,
    input  wire bbd_pkg::t_tag    i_tag,
    output logic                o_valid,
    output logic [bbd_pkg::COLOR_W-1:0]   o_red,
    output logic [bbd_pkg::COLOR_W-1:0]   o_green,
    output logic [bbd_pkg::COLOR_W-1:0]   o_blue,
    output logic [bbd_pkg::COL_OUT_W-1:0] o_pixel_column,
    output logic [bbd_pkg::ROW_W-1:0]     o_pixel_row,
    output logic                o_frame_last
);

    localparam int unsigned DS = DROP_SHIFT;

    logic [bbd_pkg::SUM_W-1:0] red_full;
    logic [bbd_pkg::SUM_W-1:0] green_full;
    logic [bbd_pkg::SUM_W-1:0] blue_full;

    logic                             r_valid;
    logic [bbd_pkg::COLOR_W-1:0]      r_red;
    logic [bbd_pkg::COLOR_W-1:0]      r_green;
    logic [bbd_pkg::COLOR_W-1:0]      r_blue;
    logic [bbd_pkg::COL_OUT_W-1:0]    r_col;
    logic [bbd_pkg::ROW_W-1:0]        r_row;
    logic                             r_last;

    always_comb begin
        unique case (i_tag.site)
            bbd_pkg::SITE_GR: begin
                red_full   = bbd_pkg::pair_mean(i_win[1][0], i_win[1][2], DS);
                green_full = bbd_pkg::keep(i_win[1][1], DS);
                blue_full  = bbd_pkg::pair_mean(i_win[0][1], i_win[2][1], DS);
            end
            bbd_pkg::SITE_R: begin
                red_full   = bbd_pkg::keep(i_win[1][1], DS);
                green_full = bbd_pkg::quad_mean(i_win[0][1], i_win[1][0],
                                                i_win[1][2], i_win[2][1], DS);
                blue_full  = bbd_pkg::quad_mean(i_win[0][0], i_win[0][2],
                                                i_win[2][0], i_win[2][2], DS);
            end
            bbd_pkg::SITE_B: begin
                red_full   = bbd_pkg::quad_mean(i_win[0][0], i_win[0][2],
                                                i_win[2][0], i_win[2][2], DS);
                green_full = bbd_pkg::quad_mean(i_win[0][1], i_win[1][0],
                                                i_win[1][2], i_win[2][1], DS);
                blue_full  = bbd_pkg::keep(i_win[1][1], DS);
            end
            default: begin
                red_full   = bbd_pkg::pair_mean(i_win[0][1], i_win[2][1], DS);
                green_full = bbd_pkg::keep(i_win[1][1], DS);
                blue_full  = bbd_pkg::pair_mean(i_win[1][0], i_win[1][2], DS);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_red   <= bbd_pkg::sat8(red_full);
            r_green <= bbd_pkg::sat8(green_full);
            r_blue  <= bbd_pkg::sat8(blue_full);
            r_col   <= i_tag.cc;
            r_row   <= i_tag.cr;
            r_last  <= i_tag.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_pixel_column = r_col;
    assign o_pixel_row    = r_row;
    assign o_frame_last   = r_last;

endmodule

`default_nettype wire

// ===== hdl/bilinear_bayer_demosaic.sv =====
// top level of the bilinear demosaic for grbg raw frames
`default_nettype none

// Takes one 16-bit raw sample per clock in raster order and returns 8-bit red,
// green and blue for every interior pixel, one result per clock when neither
// side stalls; border rows and columns give no result. The sample at row r,
// column c yields the pixel at (r-1, c-1) through stage 1, the window and the output register.
// Throughput is set by the two line stores, each doing one read and one write
// per clock; the window, adders and output register keep that pace. A stall
// on the output holds the whole pipeline while the output register is full.
// Frame size is read from the width and height registers, clamped to
// 4..MAX_WIDTH and 4..16384, and should be changed only while the block is idle.

`include "bilinear_bayer_demosaic_assert.svh"

module bilinear_bayer_demosaic #(
    parameter int MAX_WIDTH  = 4096,
    parameter int DROP_SHIFT = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire [bbd_pkg::SAMPLE_W-1:0]     i_raw_sample,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [bbd_pkg::COLOR_W-1:0]     o_red,
    output logic [bbd_pkg::COLOR_W-1:0]     o_green,
    output logic [bbd_pkg::COLOR_W-1:0]     o_blue,
    output logic [bbd_pkg::COL_OUT_W-1:0]   o_pixel_column,
    output logic [bbd_pkg::ROW_W-1:0]       o_pixel_row,
    output logic        o_frame_last,
    input  wire         i_cfg_we,
    input  wire [bbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [bbd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > bbd_pkg::WIDTH_CFG_W) ? CNT_W + 1
                                                              : bbd_pkg::WIDTH_CFG_W;
    localparam int RCW   = bbd_pkg::ROW_CMP_W;

    // configuration
    logic [bbd_pkg::WIDTH_CFG_W-1:0]  r_frame_width;
    logic [bbd_pkg::HEIGHT_CFG_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbd_pkg::WIDTH_CFG_W'(bbd_pkg::WIDTH_RESET);
            r_frame_height <= bbd_pkg::HEIGHT_CFG_W'(bbd_pkg::HEIGHT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == bbd_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[bbd_pkg::WIDTH_CFG_W-1:0];
            end else if (i_cfg_index == bbd_pkg::REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[bbd_pkg::HEIGHT_CFG_W-1:0];
            end
        end
    end

    logic [CMP_W-1:0] w_cfg;
    logic [CMP_W-1:0] w_used;
    logic [RCW-1:0]   h_used;

    always_comb begin
        w_cfg = CMP_W'(r_frame_width);
        priority if (w_cfg < CMP_W'(bbd_pkg::MIN_DIM)) begin
            w_used = CMP_W'(bbd_pkg::MIN_DIM);
        end else if (w_cfg > CMP_W'(MAX_WIDTH)) begin
            w_used = CMP_W'(MAX_WIDTH);
        end else begin
            w_used = w_cfg;
        end
        priority if (r_frame_height < RCW'(bbd_pkg::MIN_DIM)) begin
            h_used = RCW'(bbd_pkg::MIN_DIM);
        end else if (r_frame_height > RCW'(bbd_pkg::HEIGHT_MAX)) begin
            h_used = RCW'(bbd_pkg::HEIGHT_MAX);
        end else begin
            h_used = r_frame_height;
        end
    end

    // handshake and pipeline enable
    logic en;
    logic accept;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;
    assign accept  = i_valid && en;

    // position of the incoming sample
    logic [CNT_W-1:0]            r_col_cnt;
    logic [bbd_pkg::ROW_W-1:0]   r_row_cnt;
    logic                        wrap_col;
    logic [CNT_W-1:0]            col_a;
    logic [RCW-1:0]              row_b;
    logic [bbd_pkg::ROW_W-1:0]   row_a;
    logic [CMP_W-1:0]            col_inc;
    logic [RCW-1:0]              row_inc;
    logic [CNT_W-1:0]            n_col_cnt;
    logic [bbd_pkg::ROW_W-1:0]   n_row_cnt;
    logic [CNT_W-1:0]            cc;
    logic [bbd_pkg::ROW_W-1:0]   cr;
    bbd_pkg::t_tag               tag_in;
    logic                        emit_in;

    always_comb begin
        wrap_col = CMP_W'(r_col_cnt) >= w_used;
        col_a    = wrap_col ? '0 : r_col_cnt;
        row_b    = RCW'(r_row_cnt) + RCW'(wrap_col);
        row_a    = (row_b >= h_used) ? '0 : row_b[bbd_pkg::ROW_W-1:0];

        col_inc  = CMP_W'(col_a) + CMP_W'(1);
        row_inc  = RCW'(row_a) + RCW'(1);
        if (col_inc >= w_used) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= h_used) ? '0 : row_inc[bbd_pkg::ROW_W-1:0];
        end else begin
            n_col_cnt = col_inc[CNT_W-1:0];
            n_row_cnt = row_a;
        end

        cc      = col_a - CNT_W'(1);
        cr      = row_a - bbd_pkg::ROW_W'(1);
        emit_in = (row_a >= bbd_pkg::ROW_W'(bbd_pkg::FIRST_OUT))
               && (col_a >= CNT_W'(bbd_pkg::FIRST_OUT));

        tag_in.cc   = bbd_pkg::COL_OUT_W'(cc);
        tag_in.cr   = cr;
        tag_in.last = (RCW'(row_a) == h_used - RCW'(1))
                   && (CMP_W'(col_a) == w_used - CMP_W'(1));
        unique case ({cr[0], cc[0]})
            2'b00:   tag_in.site = bbd_pkg::SITE_GR;
            2'b01:   tag_in.site = bbd_pkg::SITE_R;
            2'b10:   tag_in.site = bbd_pkg::SITE_B;
            default: tag_in.site = bbd_pkg::SITE_GB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // stage 1: line store read data lines up with the sample
    logic                r_s1_valid;
    logic [CNT_W-1:0]    r_s1_col;
    bbd_pkg::t_sample    r_s1_sample;
    logic                r_s1_emit;
    bbd_pkg::t_tag       r_s1_tag;
    bbd_pkg::t_sample    up_data;
    bbd_pkg::t_sample    mid_data;
    logic                s1_adv;

    assign s1_adv = en && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col    <= col_a;
            r_s1_sample <= i_raw_sample;
            r_s1_emit   <= emit_in;
            r_s1_tag    <= tag_in;
        end
    end

    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CNT_W)
    ) u_store_upper (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col_a),
        .o_rd_data (up_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (mid_data)
    );

    bbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (CNT_W)
    ) u_store_middle (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col_a),
        .o_rd_data (mid_data),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (r_s1_sample)
    );

    // stage 2: 3x3 window
    bbd_pkg::t_window r_win;
    logic             r_s2_valid;
    bbd_pkg::t_tag    r_s2_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= up_data;
            r_win[1][2] <= mid_data;
            r_win[2][2] <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // stage 3: colors into the output register
    bbd_color #(
        .DROP_SHIFT (DROP_SHIFT)
    ) u_color (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (r_s2_valid),
        .i_win          (r_win),
        .i_tag          (r_s2_tag),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_frame_last   (o_frame_last)
    );

    `BBD_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid, "stall without a held result")
    `BBD_ASSERT_NOW(a_no_border_row, i_clk, i_rst_n, r_s2_valid, r_s2_tag.cr != '0, "result from border row")
    `BBD_ASSERT_NEXT(a_window_holds, i_clk, i_rst_n, o_stall, $stable(r_win), "window moved during stall")

endmodule

`default_nettype wire

// ===== tb/sv/bilinear_bayer_demosaic_tb.sv =====
// self-checking testbench for the grbg bilinear demosaic, with its own pixel predictor
module bilinear_bayer_demosaic_tb;

    localparam int MAX_W        = 4096;
    localparam int DROP         = 8;
    localparam int PIPE_SETTLE  = 8;
    localparam int HOLD_LEN     = 200;
    localparam int HOLD_SPACING = 600;
    localparam int FRAME_TARGET = 260;

    typedef struct {
        logic [bbd_pkg::COLOR_W-1:0]   red;
        logic [bbd_pkg::COLOR_W-1:0]   green;
        logic [bbd_pkg::COLOR_W-1:0]   blue;
        logic [bbd_pkg::COL_OUT_W-1:0] column;
        logic [bbd_pkg::ROW_W-1:0]     row;
        logic                          last;
    } t_pixel;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    bbd_pkg::t_sample                  i_raw_sample = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [bbd_pkg::COLOR_W-1:0]       o_red;
    logic [bbd_pkg::COLOR_W-1:0]       o_green;
    logic [bbd_pkg::COLOR_W-1:0]       o_blue;
    logic [bbd_pkg::COL_OUT_W-1:0]     o_pixel_column;
    logic [bbd_pkg::ROW_W-1:0]         o_pixel_row;
    logic                              o_frame_last;
    logic                              i_cfg_we = 1'b0;
    logic [bbd_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [bbd_pkg::CFG_DATA_W-1:0]    i_cfg_data = '0;

    bilinear_bayer_demosaic #(
        .MAX_WIDTH  (MAX_W),
        .DROP_SHIFT (DROP)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_raw_sample   (i_raw_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_frame_last   (o_frame_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // predictor state
    int unsigned upper_line [MAX_W];
    int unsigned middle_line [MAX_W];
    int unsigned win [3][3];
    int          col_pos = 0;
    int          row_pos = 0;
    int          width_reg = bbd_pkg::WIDTH_RESET;
    int          height_reg = bbd_pkg::HEIGHT_RESET;

    bbd_pkg::t_sample raw_backlog [$];
    t_pixel      predicted_pixels [$];
    bit          sample_taken = 1'b0;
    int          pixels_seen = 0;
    int          mismatches = 0;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;
    int          hold_cycles = 0;
    int          next_hold = 40;

    function automatic int used_width();
        return width_reg < bbd_pkg::MIN_DIM ? bbd_pkg::MIN_DIM :
               (width_reg > MAX_W ? MAX_W : width_reg);
    endfunction

    function automatic int used_height();
        return height_reg < bbd_pkg::MIN_DIM ? bbd_pkg::MIN_DIM :
               (height_reg > bbd_pkg::HEIGHT_MAX ? bbd_pkg::HEIGHT_MAX : height_reg);
    endfunction

    function automatic int unsigned mean2(input int unsigned a, input int unsigned b);
        return (a + b + 1) >> (1 + DROP);
    endfunction

    function automatic int unsigned mean4(input int unsigned a, input int unsigned b,
                                          input int unsigned c, input int unsigned d);
        return (a + b + c + d + 2) >> (2 + DROP);
    endfunction

    function automatic logic [bbd_pkg::COLOR_W-1:0] clip8(input int unsigned v);
        return v > bbd_pkg::COLOR_MAX ? bbd_pkg::COLOR_W'(bbd_pkg::COLOR_MAX)
                                      : bbd_pkg::COLOR_W'(v);
    endfunction

    // samples still needed to reach the start of the next frame
    function automatic int left_in_frame();
        int w;
        int h;
        int c;
        int r;
        w = used_width();
        h = used_height();
        c = col_pos;
        r = row_pos;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= h) r = 0;
        if (r == 0 && c == 0) return 0;
        return (h - r) * w - c;
    endfunction

    task automatic demosaic_step(input bbd_pkg::t_sample s);
        int             w;
        int             h;
        int             c;
        int             r;
        int unsigned    up;
        int unsigned    mid;
        int unsigned    rd;
        int unsigned    gr;
        int unsigned    bl;
        bbd_pkg::t_site site;
        t_pixel         px;
        w = used_width();
        h = used_height();
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = s;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = s;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
        if (r >= bbd_pkg::FIRST_OUT && c >= bbd_pkg::FIRST_OUT) begin
            px.column = bbd_pkg::COL_OUT_W'(c - 1);
            px.row = bbd_pkg::ROW_W'(r - 1);
            px.last = (r == h - 1) && (c == w - 1);
            if (!px.row[0] && !px.column[0]) site = bbd_pkg::SITE_GR;
            else if (!px.row[0]) site = bbd_pkg::SITE_R;
            else if (!px.column[0]) site = bbd_pkg::SITE_B;
            else site = bbd_pkg::SITE_GB;
            case (site)
                bbd_pkg::SITE_GR: begin
                    rd = mean2(win[1][0], win[1][2]);
                    gr = win[1][1] >> DROP;
                    bl = mean2(win[0][1], win[2][1]);
                end
                bbd_pkg::SITE_R: begin
                    rd = win[1][1] >> DROP;
                    gr = mean4(win[0][1], win[1][0], win[1][2], win[2][1]);
                    bl = mean4(win[0][0], win[0][2], win[2][0], win[2][2]);
                end
                bbd_pkg::SITE_B: begin
                    rd = mean4(win[0][0], win[0][2], win[2][0], win[2][2]);
                    gr = mean4(win[0][1], win[1][0], win[1][2], win[2][1]);
                    bl = win[1][1] >> DROP;
                end
                default: begin
                    rd = mean2(win[0][1], win[2][1]);
                    gr = win[1][1] >> DROP;
                    bl = mean2(win[1][0], win[1][2]);
                end
            endcase
            px.red = clip8(rd);
            px.green = clip8(gr);
            px.blue = clip8(bl);
            predicted_pixels.push_back(px);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input t_pixel px);
        if (got != want)
            report_mismatch($sformatf("%s at row %0d column %0d: got %0d, expected %0d",
                                      name, px.row, px.column, got, want));
    endtask

    // monitor: config mirror, transfer detection, result checks
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                pixels_seen++;
                if (predicted_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel at row %0d column %0d with none expected",
                                              o_pixel_row, o_pixel_column));
                end else begin
                    want = predicted_pixels.pop_front();
                    check_field("red", o_red, want.red, want);
                    check_field("green", o_green, want.green, want);
                    check_field("blue", o_blue, want.blue, want);
                    check_field("column", o_pixel_column, want.column, want);
                    check_field("row", o_pixel_row, want.row, want);
                    check_field("frame_last", o_frame_last, want.last, want);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == bbd_pkg::REG_FRAME_WIDTH)
                    width_reg = i_cfg_data[bbd_pkg::WIDTH_CFG_W-1:0];
                else if (i_cfg_index == bbd_pkg::REG_FRAME_HEIGHT)
                    height_reg = i_cfg_data[bbd_pkg::HEIGHT_CFG_W-1:0];
            end
            sample_taken = i_valid && !o_stall;
            if (sample_taken) demosaic_step(i_raw_sample);
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || sample_taken)) begin
            if (raw_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                i_raw_sample = raw_backlog.pop_front();
                i_valid = 1'b1;
            end else begin
                i_valid = 1'b0;
            end
        end
    end

    // receiver, with a long hold-off now and then so the pipeline backs up
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_stall = 1'b1;
        end else if (pixels_seen >= next_hold) begin
            hold_cycles = HOLD_LEN - 1;
            next_hold += HOLD_SPACING;
            i_stall = 1'b1;
        end else begin
            i_stall = ($urandom_range(99) < recv_gap_pct);
        end
    end

    function automatic bbd_pkg::t_sample random_raw();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return bbd_pkg::t_sample'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic int unsigned pick_width_code();
        case ($urandom_range(9))
            0: return 2 * $urandom_range(2, 12) + 1;
            1: return 16'h4000 | (2 * $urandom_range(2, 10));
            2: return $urandom_range(0, 3);
            3: return 2 * $urandom_range(20, 60);
            default: return 2 * $urandom_range(2, 12);
        endcase
    endfunction

    function automatic int unsigned pick_height_code();
        case ($urandom_range(5))
            0: return $urandom_range(0, 3);
            1: return 2 * $urandom_range(2, 4) + 1;
            default: return 2 * $urandom_range(2, 5);
        endcase
    endfunction

    task automatic feed(input int n);
        repeat (n) raw_backlog.push_back(random_raw());
    endtask

    task automatic wait_idle();
        while (raw_backlog.size() != 0 || i_valid || predicted_pixels.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bbd_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned data);
        i_cfg_index = idx;
        i_cfg_data = bbd_pkg::CFG_DATA_W'(data);
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // size changes that may widen the frame happen only at a frame start
    task automatic set_frame(input int unsigned wcode, input int unsigned hcode);
        wait_idle();
        if (left_in_frame() != 0) begin
            feed(left_in_frame());
            wait_idle();
        end
        write_reg(bbd_pkg::REG_FRAME_WIDTH, wcode);
        write_reg(bbd_pkg::REG_FRAME_HEIGHT, hcode);
    endtask

    task automatic random_frames(input int target);
        int sent;
        int chunk;
        sent = 0;
        while (sent < target) begin
            set_frame(pick_width_code(), pick_height_code());
            chunk = used_width() * used_height();
            if ($urandom_range(3) == 0) begin
                chunk = $urandom_range(1, chunk - 1);
                feed(chunk);
                sent += chunk;
                wait_idle();
                // shrink mid-frame so the position may land outside the frame
                write_reg(bbd_pkg::REG_FRAME_WIDTH,
                          $urandom_range(bbd_pkg::MIN_DIM, used_width()));
                write_reg(bbd_pkg::REG_FRAME_HEIGHT,
                          $urandom_range(bbd_pkg::MIN_DIM, used_height()));
                chunk = left_in_frame();
            end
            feed(chunk);
            sent += chunk;
        end
    endtask

    localparam bbd_pkg::t_sample DIRECTED [16] = '{
        16'hFFFF, 16'h0000, 16'h0180, 16'h017F,
        16'h0000, 16'hFFFF, 16'h00FF, 16'h0100,
        16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000,
        16'h7FFF, 16'hFFFF, 16'hFFFE, 16'h0000
    };

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_gap_pct = 18;
        recv_gap_pct = 58;
        set_frame(4, 4);
        foreach (DIRECTED[i]) raw_backlog.push_back(DIRECTED[i]);
        set_frame(3, 0);
        feed(used_width() * used_height());
        random_frames(FRAME_TARGET);

        send_gap_pct = 58;
        recv_gap_pct = 18;
        random_frames(FRAME_TARGET);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        random_frames(FRAME_TARGET);

        // width above the store depth, then narrowed mid-row so the column wraps
        set_frame(8191, 4);
        feed(40);
        wait_idle();
        write_reg(bbd_pkg::REG_FRAME_WIDTH, 4);
        feed(left_in_frame());

        set_frame(4, 32767);
        feed(40);
        wait_idle();
        // row now beyond the new height, so the next transfer starts at row 0
        write_reg(bbd_pkg::REG_FRAME_HEIGHT, 6);
        feed(4 * 6);
        wait_idle();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(12 * 4000000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bbd_pkg.sv
hdl/bbd_line_store.sv
hdl/bbd_color.sv
hdl/bilinear_bayer_demosaic.sv
tb/sv/bilinear_bayer_demosaic_tb.sv
